FILE: src/jsv_pkg.sv
// Shared types, constants and helper functions for the JSON syntax validator.
package jsv_pkg;

  // Nesting capacity and derived widths
  localparam int unsigned MaxNest   = 32;
  localparam int unsigned NestW     = $clog2(MaxNest + 1);
  localparam int unsigned StackIdxW = (MaxNest > 1) ? $clog2(MaxNest) : 1;

  // Fixed field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LimitW = 6;
  localparam int unsigned SubW   = 3;
  localparam int unsigned KindW  = 2;

  localparam logic [LimitW-1:0] LimitReset = LimitW'(32);

  // Result status codes
  typedef enum logic [1:0] {
    StatusBusy  = 2'd0,
    StatusValid = 2'd1,
    StatusError = 2'd2
  } status_e;

  // Literal kinds
  typedef enum logic [KindW-1:0] {
    LitTrue  = 2'd0,
    LitFalse = 2'd1,
    LitNull  = 2'd2
  } lit_kind_e;

  // Parser modes, one-hot
  typedef enum logic [22:0] {
    ModeStart     = 23'h000001,
    ModeObjOpen   = 23'h000002,
    ModeKeyExpect = 23'h000004,
    ModeKeyStr    = 23'h000008,
    ModeKeyEsc    = 23'h000010,
    ModeKeyHex    = 23'h000020,
    ModeColon     = 23'h000040,
    ModeValue     = 23'h000080,
    ModeArrOpen   = 23'h000100,
    ModeValStr    = 23'h000200,
    ModeValEsc    = 23'h000400,
    ModeValHex    = 23'h000800,
    ModeLiteral   = 23'h001000,
    ModeNumSign   = 23'h002000,
    ModeNumZero   = 23'h004000,
    ModeNumInt    = 23'h008000,
    ModeNumDot    = 23'h010000,
    ModeNumFrac   = 23'h020000,
    ModeNumExp    = 23'h040000,
    ModeNumEsign  = 23'h080000,
    ModeNumEdig   = 23'h100000,
    ModeAfter     = 23'h200000,
    ModeDone      = 23'h400000
  } mode_e;

  // Input word
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last;
  } in_word_t;

  // Result word
  typedef struct packed {
    status_e          status;
    logic [NestW-1:0] nest_level;
  } out_word_t;

  // Byte classes used by the parser
  typedef struct packed {
    logic ws;
    logic digit;
    logic digit19;
    logic hex;
    logic ctrl;
    logic esc_simple;
  } byte_class_t;

  // Length of each literal
  function automatic logic [SubW-1:0] lit_len(input logic [KindW-1:0] kind);
    logic [SubW-1:0] len;
    unique case (kind)
      LitFalse: len = SubW'(5);
      default:  len = SubW'(4);
    endcase
    return len;
  endfunction

  // Expected character of a literal at a position
  function automatic logic [ByteW-1:0] lit_char(input logic [KindW-1:0] kind,
                                                 input logic [SubW-1:0]  idx);
    logic [ByteW-1:0] ch;
    ch = 8'h00;
    unique case (kind)
      LitFalse: begin
        unique case (idx)
          3'd0: ch = "f";
          3'd1: ch = "a";
          3'd2: ch = "l";
          3'd3: ch = "s";
          3'd4: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      LitNull: begin
        unique case (idx)
          3'd0: ch = "n";
          3'd1: ch = "u";
          3'd2: ch = "l";
          3'd3: ch = "l";
          default: ch = 8'h00;
        endcase
      end
      default: begin
        unique case (idx)
          3'd0: ch = "t";
          3'd1: ch = "r";
          3'd2: ch = "u";
          3'd3: ch = "e";
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage

FILE: src/jsv_byte_class.sv
// Character classifier for one input byte.
module jsv_byte_class (
  input  logic [jsv_pkg::ByteW-1:0] data_byte_i,
  output jsv_pkg::byte_class_t      class_o
);

  logic [jsv_pkg::ByteW-1:0] b;
  assign b = data_byte_i;

  // Plain range and set compares
  always_comb begin
    class_o.ws         = (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
    class_o.digit      = (b >= "0") && (b <= "9");
    class_o.digit19    = (b >= "1") && (b <= "9");
    class_o.hex        = ((b >= "0") && (b <= "9")) || ((b >= "A") && (b <= "F")) ||
                         ((b >= "a") && (b <= "f"));
    class_o.ctrl       = (b < 8'h20);
    class_o.esc_simple = (b == "\"") || (b == "\\") || (b == "/") || (b == "b") ||
                         (b == "f") || (b == "n") || (b == "r") || (b == "t");
  end

endmodule

FILE: src/jsv_parser.sv
// Parser state, container stack and per-byte next-state logic.
module jsv_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  jsv_pkg::in_word_t          word_i,
  input  logic [jsv_pkg::LimitW-1:0] depth_limit_i,
  output jsv_pkg::out_word_t         result_o
);

  jsv_pkg::mode_e                      mode_q, mode_d;
  logic [jsv_pkg::NestW-1:0]           nest_q, nest_d;
  logic [jsv_pkg::SubW-1:0]            sub_q, sub_d;
  logic [jsv_pkg::KindW-1:0]           kind_q, kind_d;
  logic                                err_q, err_d;
  logic [jsv_pkg::MaxNest-1:0]         stack_q;

  jsv_pkg::byte_class_t                cls;
  logic [jsv_pkg::ByteW-1:0]           b;
  logic [jsv_pkg::LimitW-1:0]          lim;
  logic                                lim_hit;
  logic                                top_obj;
  logic [jsv_pkg::StackIdxW-1:0]       rd_idx;
  logic [jsv_pkg::StackIdxW-1:0]       wr_idx;
  logic [jsv_pkg::NestW-1:0]           nest_dec;

  // Next-state working values
  jsv_pkg::mode_e                      p_mode;
  logic [jsv_pkg::NestW-1:0]           p_nest;
  logic [jsv_pkg::SubW-1:0]            p_sub;
  logic [jsv_pkg::KindW-1:0]           p_kind;
  logic                                p_fail;
  logic                                act_vs, act_av, act_push, act_pop;
  logic                                push_obj, pop_obj;
  logic                                stack_we;
  logic [jsv_pkg::SubW-1:0]            sub_inc;
  logic [jsv_pkg::KindW-1:0]           lit_k;
  logic                                err_next;
  jsv_pkg::status_e                    status;

  assign b = word_i.data_byte;

  jsv_byte_class u_class (
    .data_byte_i (b),
    .class_o     (cls)
  );

  // Effective limit and stack top
  assign lim      = (depth_limit_i > jsv_pkg::LimitW'(jsv_pkg::MaxNest))
                    ? jsv_pkg::LimitW'(jsv_pkg::MaxNest) : depth_limit_i;
  assign lim_hit  = (jsv_pkg::NestW'(lim) <= nest_q);
  assign nest_dec = nest_q - jsv_pkg::NestW'(1);
  assign rd_idx   = nest_dec[jsv_pkg::StackIdxW-1:0];
  assign wr_idx   = nest_q[jsv_pkg::StackIdxW-1:0];
  assign top_obj  = stack_q[rd_idx];
  assign sub_inc  = sub_q + jsv_pkg::SubW'(1);
  assign lit_k    = (kind_q > jsv_pkg::KindW'(jsv_pkg::LitNull))
                    ? jsv_pkg::KindW'(jsv_pkg::LitTrue) : kind_q;

  // Per-byte transition
  always_comb begin
    p_mode   = mode_q;
    p_nest   = nest_q;
    p_sub    = sub_q;
    p_kind   = kind_q;
    p_fail   = 1'b0;
    act_vs   = 1'b0;
    act_av   = 1'b0;
    act_push = 1'b0;
    act_pop  = 1'b0;
    push_obj = 1'b0;
    pop_obj  = 1'b0;
    stack_we = 1'b0;

    unique case (mode_q)
      jsv_pkg::ModeStart: begin
        if (b == "{") begin
          act_push = 1'b1;
          push_obj = 1'b1;
        end else if (!cls.ws) begin
          p_fail = 1'b1;
        end
      end
      jsv_pkg::ModeObjOpen: begin
        if (b == "\"") begin
          p_mode = jsv_pkg::ModeKeyStr;
        end else if (b == "}") begin
          act_pop = 1'b1;
          pop_obj = 1'b1;
        end else if (!cls.ws) begin
          p_fail = 1'b1;
        end
      end
      jsv_pkg::ModeKeyExpect: begin
        if (b == "\"") p_mode = jsv_pkg::ModeKeyStr;
        else if (!cls.ws) p_fail = 1'b1;
      end
      jsv_pkg::ModeKeyStr: begin
        if (b == "\"") p_mode = jsv_pkg::ModeColon;
        else if (b == "\\") p_mode = jsv_pkg::ModeKeyEsc;
        else if (cls.ctrl) p_fail = 1'b1;
      end
      jsv_pkg::ModeKeyEsc: begin
        if (cls.esc_simple) begin
          p_mode = jsv_pkg::ModeKeyStr;
        end else if (b == "u") begin
          p_sub  = '0;
          p_mode = jsv_pkg::ModeKeyHex;
        end else begin
          p_fail = 1'b1;
        end
      end
      jsv_pkg::ModeKeyHex: begin
        if (!cls.hex) begin
          p_fail = 1'b1;
        end else if (sub_inc >= jsv_pkg::SubW'(4)) begin
          p_sub  = '0;
          p_mode = jsv_pkg::ModeKeyStr;
        end else begin
          p_sub = sub_inc;
        end
      end
      jsv_pkg::ModeColon: begin
        if (b == ":") p_mode = jsv_pkg::ModeValue;
        else if (!cls.ws) p_fail = 1'b1;
      end
      jsv_pkg::ModeValue: begin
        if (!cls.ws) act_vs = 1'b1;
      end
      jsv_pkg::ModeArrOpen: begin
        if (b == "]") begin
          act_pop = 1'b1;
        end else if (!cls.ws) begin
          act_vs = 1'b1;
        end
      end
      jsv_pkg::ModeValStr: begin
        if (b == "\"") p_mode = jsv_pkg::ModeAfter;
        else if (b == "\\") p_mode = jsv_pkg::ModeValEsc;
        else if (cls.ctrl) p_fail = 1'b1;
      end
      jsv_pkg::ModeValEsc: begin
        if (cls.esc_simple) begin
          p_mode = jsv_pkg::ModeValStr;
        end else if (b == "u") begin
          p_sub  = '0;
          p_mode = jsv_pkg::ModeValHex;
        end else begin
          p_fail = 1'b1;
        end
      end
      jsv_pkg::ModeValHex: begin
        if (!cls.hex) begin
          p_fail = 1'b1;
        end else if (sub_inc >= jsv_pkg::SubW'(4)) begin
          p_sub  = '0;
          p_mode = jsv_pkg::ModeValStr;
        end else begin
          p_sub = sub_inc;
        end
      end
      jsv_pkg::ModeLiteral: begin
        if ((sub_q >= jsv_pkg::lit_len(lit_k)) || (b != jsv_pkg::lit_char(lit_k, sub_q))) begin
          p_fail = 1'b1;
        end else if (sub_inc >= jsv_pkg::lit_len(lit_k)) begin
          p_sub  = '0;
          p_mode = jsv_pkg::ModeAfter;
        end else begin
          p_sub = sub_inc;
        end
      end
      jsv_pkg::ModeNumSign: begin
        if (b == "0") p_mode = jsv_pkg::ModeNumZero;
        else if (cls.digit19) p_mode = jsv_pkg::ModeNumInt;
        else p_fail = 1'b1;
      end
      jsv_pkg::ModeNumZero: begin
        if (cls.digit) p_fail = 1'b1;
        else if (b == ".") p_mode = jsv_pkg::ModeNumDot;
        else if ((b == "e") || (b == "E")) p_mode = jsv_pkg::ModeNumExp;
        else act_av = 1'b1;
      end
      jsv_pkg::ModeNumInt: begin
        if (cls.digit) p_mode = jsv_pkg::ModeNumInt;
        else if (b == ".") p_mode = jsv_pkg::ModeNumDot;
        else if ((b == "e") || (b == "E")) p_mode = jsv_pkg::ModeNumExp;
        else act_av = 1'b1;
      end
      jsv_pkg::ModeNumDot: begin
        if (cls.digit) p_mode = jsv_pkg::ModeNumFrac;
        else p_fail = 1'b1;
      end
      jsv_pkg::ModeNumFrac: begin
        if (cls.digit) p_mode = jsv_pkg::ModeNumFrac;
        else if ((b == "e") || (b == "E")) p_mode = jsv_pkg::ModeNumExp;
        else act_av = 1'b1;
      end
      jsv_pkg::ModeNumExp: begin
        if ((b == "+") || (b == "-")) p_mode = jsv_pkg::ModeNumEsign;
        else if (cls.digit) p_mode = jsv_pkg::ModeNumEdig;
        else p_fail = 1'b1;
      end
      jsv_pkg::ModeNumEsign: begin
        if (cls.digit) p_mode = jsv_pkg::ModeNumEdig;
        else p_fail = 1'b1;
      end
      jsv_pkg::ModeNumEdig: begin
        if (!cls.digit) act_av = 1'b1;
      end
      jsv_pkg::ModeAfter: begin
        act_av = 1'b1;
      end
      jsv_pkg::ModeDone: begin
        if (!cls.ws) p_fail = 1'b1;
      end
      default: begin
        p_fail = 1'b1;
      end
    endcase

    // Start of a value
    if (act_vs) begin
      priority if (b == "\"") begin
        p_mode = jsv_pkg::ModeValStr;
      end else if ((b == "t") || (b == "f") || (b == "n")) begin
        p_kind = (b == "t") ? jsv_pkg::LitTrue :
                 (b == "f") ? jsv_pkg::LitFalse : jsv_pkg::LitNull;
        p_sub  = jsv_pkg::SubW'(1);
        p_mode = jsv_pkg::ModeLiteral;
      end else if (b == "-") begin
        p_mode = jsv_pkg::ModeNumSign;
      end else if (b == "0") begin
        p_mode = jsv_pkg::ModeNumZero;
      end else if (cls.digit19) begin
        p_mode = jsv_pkg::ModeNumInt;
      end else if (b == "{") begin
        act_push = 1'b1;
        push_obj = 1'b1;
      end else if (b == "[") begin
        act_push = 1'b1;
      end else begin
        p_fail = 1'b1;
      end
    end

    // Separator or closer after a value
    if (act_av) begin
      p_mode = jsv_pkg::ModeAfter;
      priority if (cls.ws) begin
        p_mode = jsv_pkg::ModeAfter;
      end else if (b == ",") begin
        if (nest_q == '0) p_fail = 1'b1;
        else p_mode = top_obj ? jsv_pkg::ModeKeyExpect : jsv_pkg::ModeValue;
      end else if (b == "}") begin
        act_pop = 1'b1;
        pop_obj = 1'b1;
      end else if (b == "]") begin
        act_pop = 1'b1;
      end else begin
        p_fail = 1'b1;
      end
    end

    // Open a container
    if (act_push) begin
      if (lim_hit) begin
        p_fail = 1'b1;
      end else begin
        stack_we = 1'b1;
        p_nest   = nest_q + jsv_pkg::NestW'(1);
        p_mode   = push_obj ? jsv_pkg::ModeObjOpen : jsv_pkg::ModeArrOpen;
      end
    end

    // Close a container
    if (act_pop) begin
      if ((nest_q == '0) || (top_obj != pop_obj)) begin
        p_fail = 1'b1;
      end else begin
        p_nest = nest_dec;
        p_mode = (nest_dec == '0) ? jsv_pkg::ModeDone : jsv_pkg::ModeAfter;
      end
    end
  end

  // Result word and committed state
  assign err_next = err_q | p_fail;

  always_comb begin
    if (err_next) status = jsv_pkg::StatusError;
    else if (word_i.last) begin
      status = (p_mode == jsv_pkg::ModeDone) ? jsv_pkg::StatusValid : jsv_pkg::StatusError;
    end else status = jsv_pkg::StatusBusy;
  end

  assign result_o.status     = status;
  assign result_o.nest_level = err_q ? nest_q : p_nest;

  always_comb begin
    mode_d = mode_q;
    nest_d = nest_q;
    sub_d  = sub_q;
    kind_d = kind_q;
    err_d  = err_q;
    if (step_i) begin
      if (word_i.last) begin
        mode_d = jsv_pkg::ModeStart;
        nest_d = '0;
        sub_d  = '0;
        kind_d = '0;
        err_d  = 1'b0;
      end else if (!err_q) begin
        mode_d = p_mode;
        nest_d = p_nest;
        sub_d  = p_sub;
        kind_d = p_kind;
        err_d  = p_fail;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsv_pkg::ModeStart;
      nest_q <= '0;
      sub_q  <= '0;
      kind_q <= '0;
      err_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      nest_q <= nest_d;
      sub_q  <= sub_d;
      kind_q <= kind_d;
      err_q  <= err_d;
    end
  end

  // Container kinds, 1 = object; only pushed levels are read
  always_ff @(posedge clk_i) begin
    if (step_i && !err_q && stack_we) begin
      stack_q[wr_idx] <= push_obj;
    end
  end

endmodule

FILE: src/json_syntax_validator_core.sv
// Streaming JSON syntax validator: input register, parser and result register.
// An accepted word is held in the input register; its result from the parser is
// captured in the result register when the output can advance.
// Throughput: one byte per cycle; while a finished result waits, one more byte
// is held in the input register before the input stalls.
// Reset: rst_ni clears all control state, the parser returns to expecting the
// opening brace and depth_limit returns to 32; the container stack is not cleared.
module json_syntax_validator_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  jsv_pkg::in_word_t          in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output jsv_pkg::out_word_t         out_word_o,
  input  logic                       cfg_we_i,
  input  logic [jsv_pkg::LimitW-1:0] cfg_wdata_i
);

  logic                       in_valid_q, in_valid_d;
  jsv_pkg::in_word_t          in_word_q;
  logic                       out_valid_q, out_valid_d;
  jsv_pkg::out_word_t         out_word_q;
  logic [jsv_pkg::LimitW-1:0] depth_limit_q;
  logic                       adv;
  logic                       in_fire;
  logic                       step;
  jsv_pkg::out_word_t         result;

  // Handshake and pipeline advance
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign step       = in_valid_q && adv;

  assign in_valid_d  = in_ready_o ? in_valid_i : in_valid_q;
  assign out_valid_d = adv ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      depth_limit_q <= jsv_pkg::LimitReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) depth_limit_q <= cfg_wdata_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) in_word_q <= in_word_i;
    if (step) out_word_q <= result;
  end

  jsv_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .word_i        (in_word_q),
    .depth_limit_i (depth_limit_q),
    .result_o      (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: dv/json_syntax_validator_core_tb.sv
// Testbench for the streaming JSON syntax validator: scoreboard against a local parser model.
`timescale 1ns / 1ps

module json_syntax_validator_core_tb;
  import jsv_pkg::*;

  localparam int unsigned StallLimit = 2000;

  // DUT signals, all inputs known from time zero
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_word_t           in_word_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_word_t          out_word_o;
  logic               cfg_we_i    = 1'b0;
  logic [LimitW-1:0]  cfg_wdata_i = LimitReset;

  json_syntax_validator_core uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_word_i,
    .out_valid_o,
    .out_ready_i,
    .out_word_o,
    .cfg_we_i,
    .cfg_wdata_i
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Idle rates in percent, per side
  int unsigned tx_idle_pct = 13;
  int unsigned rx_idle_pct = 82;

  int unsigned fail_cnt     = 0;
  int unsigned bytes_sent   = 0;
  int unsigned stall_cycles = 0;

  out_word_t   pending_status_q[$];
  logic [7:0]  doc_bytes[$];

  // ---------------------------------------------------------------------------
  // Parser model state
  // ---------------------------------------------------------------------------
  mode_e             parse_state;
  logic              obj_stack [MaxNest];
  int unsigned       nest_depth;
  int unsigned       sub_pos;
  lit_kind_e         lit_sel;
  logic              parse_err;
  logic [LimitW-1:0] limit_reg;

  function automatic logic is_space(logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A;
  endfunction

  function automatic logic is_dig(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_hexdig(logic [7:0] b);
    return is_dig(b) || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
  endfunction

  function automatic string literal_text(lit_kind_e k);
    case (k)
      LitFalse: return "false";
      LitNull:  return "null";
      default:  return "true";
    endcase
  endfunction

  function automatic void clear_parser();
    parse_state = ModeStart;
    foreach (obj_stack[i]) obj_stack[i] = 1'b0;
    nest_depth = 0;
    sub_pos    = 0;
    lit_sel    = LitTrue;
    parse_err  = 1'b0;
  endfunction

  function automatic void push_level(logic is_obj);
    int unsigned cap;
    if (limit_reg > MaxNest) cap = MaxNest;
    else cap = limit_reg;
    if (nest_depth >= cap) begin
      parse_err = 1'b1;
      return;
    end
    obj_stack[nest_depth] = is_obj;
    nest_depth++;
    if (is_obj) parse_state = ModeObjOpen;
    else parse_state = ModeArrOpen;
  endfunction

  // Closer must match the open container type
  function automatic void pop_level(logic want_obj);
    if (nest_depth == 0 || obj_stack[nest_depth-1] != want_obj) begin
      parse_err = 1'b1;
      return;
    end
    nest_depth--;
    if (nest_depth == 0) parse_state = ModeDone;
    else parse_state = ModeAfter;
  endfunction

  function automatic void start_value(logic [7:0] b);
    if (b == "\"") parse_state = ModeValStr;
    else if (b == "t" || b == "f" || b == "n") begin
      if (b == "t") lit_sel = LitTrue;
      else if (b == "f") lit_sel = LitFalse;
      else lit_sel = LitNull;
      sub_pos     = 1;
      parse_state = ModeLiteral;
    end
    else if (b == "-") parse_state = ModeNumSign;
    else if (b == "0") parse_state = ModeNumZero;
    else if (b >= "1" && b <= "9") parse_state = ModeNumInt;
    else if (b == "{") push_level(1'b1);
    else if (b == "[") push_level(1'b0);
    else parse_err = 1'b1;
  endfunction

  function automatic void end_value(logic [7:0] b);
    parse_state = ModeAfter;
    if (is_space(b)) return;
    if (b == ",") begin
      if (nest_depth == 0) parse_err = 1'b1;
      else if (obj_stack[nest_depth-1]) parse_state = ModeKeyExpect;
      else parse_state = ModeValue;
    end
    else if (b == "}") pop_level(1'b1);
    else if (b == "]") pop_level(1'b0);
    else parse_err = 1'b1;
  endfunction

  function automatic void string_char(logic [7:0] b, mode_e esc_mode, mode_e end_mode);
    if (b == "\"") parse_state = end_mode;
    else if (b == "\\") parse_state = esc_mode;
    else if (b < 8'h20) parse_err = 1'b1;
  endfunction

  function automatic void escape_char(logic [7:0] b, mode_e str_mode, mode_e hex_mode);
    if (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" ||
        b == "n" || b == "r" || b == "t") parse_state = str_mode;
    else if (b == "u") begin
      sub_pos     = 0;
      parse_state = hex_mode;
    end
    else parse_err = 1'b1;
  endfunction

  // Four hex digits after \u
  function automatic void hex_char(logic [7:0] b, mode_e str_mode);
    if (!is_hexdig(b)) begin
      parse_err = 1'b1;
      return;
    end
    sub_pos++;
    if (sub_pos >= 4) begin
      sub_pos     = 0;
      parse_state = str_mode;
    end
  endfunction

  function automatic void exp_or_end(logic [7:0] b);
    if (b == "e" || b == "E") parse_state = ModeNumExp;
    else end_value(b);
  endfunction

  function automatic void advance_parser(logic [7:0] b);
    string lit;
    case (parse_state)
      ModeStart: begin
        if (b == "{") push_level(1'b1);
        else if (!is_space(b)) parse_err = 1'b1;
      end
      ModeObjOpen: begin
        if (b == "\"") parse_state = ModeKeyStr;
        else if (b == "}") pop_level(1'b1);
        else if (!is_space(b)) parse_err = 1'b1;
      end
      ModeKeyExpect: begin
        if (b == "\"") parse_state = ModeKeyStr;
        else if (!is_space(b)) parse_err = 1'b1;
      end
      ModeKeyStr: string_char(b, ModeKeyEsc, ModeColon);
      ModeKeyEsc: escape_char(b, ModeKeyStr, ModeKeyHex);
      ModeKeyHex: hex_char(b, ModeKeyStr);
      ModeColon: begin
        if (b == ":") parse_state = ModeValue;
        else if (!is_space(b)) parse_err = 1'b1;
      end
      ModeValue: begin
        if (!is_space(b)) start_value(b);
      end
      ModeArrOpen: begin
        if (b == "]") pop_level(1'b0);
        else if (!is_space(b)) start_value(b);
      end
      ModeValStr: string_char(b, ModeValEsc, ModeAfter);
      ModeValEsc: escape_char(b, ModeValStr, ModeValHex);
      ModeValHex: hex_char(b, ModeValStr);
      ModeLiteral: begin
        lit = literal_text(lit_sel);
        if (sub_pos >= lit.len() || b != lit[sub_pos]) parse_err = 1'b1;
        else begin
          sub_pos++;
          if (sub_pos >= lit.len()) begin
            sub_pos     = 0;
            parse_state = ModeAfter;
          end
        end
      end
      ModeNumSign: begin
        if (b == "0") parse_state = ModeNumZero;
        else if (b >= "1" && b <= "9") parse_state = ModeNumInt;
        else parse_err = 1'b1;
      end
      ModeNumZero: begin
        // no leading zeros
        if (is_dig(b)) parse_err = 1'b1;
        else if (b == ".") parse_state = ModeNumDot;
        else exp_or_end(b);
      end
      ModeNumInt: begin
        if (b == ".") parse_state = ModeNumDot;
        else if (!is_dig(b)) exp_or_end(b);
      end
      ModeNumDot: begin
        if (is_dig(b)) parse_state = ModeNumFrac;
        else parse_err = 1'b1;
      end
      ModeNumFrac: begin
        if (!is_dig(b)) exp_or_end(b);
      end
      ModeNumExp: begin
        if (b == "+" || b == "-") parse_state = ModeNumEsign;
        else if (is_dig(b)) parse_state = ModeNumEdig;
        else parse_err = 1'b1;
      end
      ModeNumEsign: begin
        if (is_dig(b)) parse_state = ModeNumEdig;
        else parse_err = 1'b1;
      end
      ModeNumEdig: begin
        if (!is_dig(b)) end_value(b);
      end
      ModeAfter: end_value(b);
      ModeDone: begin
        if (!is_space(b)) parse_err = 1'b1;
      end
      default: parse_err = 1'b1;
    endcase
  endfunction

  // Status word for one byte; error latches until the last byte of the document
  function automatic out_word_t syntax_status(logic [7:0] b, logic is_last);
    out_word_t r;
    if (!parse_err) advance_parser(b);
    if (parse_err) r.status = StatusError;
    else if (is_last && parse_state == ModeDone) r.status = StatusValid;
    else if (is_last) r.status = StatusError;
    else r.status = StatusBusy;
    r.nest_level = NestW'(nest_depth);
    if (is_last) clear_parser();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Document generation
  // ---------------------------------------------------------------------------
  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
  endfunction

  function automatic void put_ws();
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(3))
          0:       doc_bytes.push_back(8'h20);
          1:       doc_bytes.push_back(8'h09);
          2:       doc_bytes.push_back(8'h0D);
          default: doc_bytes.push_back(8'h0A);
        endcase
      end
    end
  endfunction

  function automatic void put_string();
    string      hexdig = "0123456789abcdefABCDEF";
    string      escs   = "\"\\/bfnrt";
    logic [7:0] c;
    doc_bytes.push_back("\"");
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(5))
        0, 1: begin
          c = 8'($urandom_range(8'h20, 8'h7E));
          if (c == "\"" || c == "\\") c = "_";
          doc_bytes.push_back(c);
        end
        2: doc_bytes.push_back(8'($urandom_range(8'h80, 8'hFF)));
        3: begin
          doc_bytes.push_back("\\");
          doc_bytes.push_back(escs[$urandom_range(7)]);
        end
        4: begin
          put_text("\\u");
          repeat (4) doc_bytes.push_back(hexdig[$urandom_range(21)]);
        end
        default: doc_bytes.push_back(8'("a" + $urandom_range(25)));
      endcase
    end
    doc_bytes.push_back("\"");
  endfunction

  function automatic void put_number();
    if ($urandom_range(1)) doc_bytes.push_back("-");
    if ($urandom_range(3) == 0) doc_bytes.push_back("0");
    else begin
      doc_bytes.push_back(8'("1" + $urandom_range(8)));
      repeat ($urandom_range(0, 3)) doc_bytes.push_back(8'("0" + $urandom_range(9)));
    end
    if ($urandom_range(1)) begin
      doc_bytes.push_back(".");
      repeat ($urandom_range(1, 3)) doc_bytes.push_back(8'("0" + $urandom_range(9)));
    end
    if ($urandom_range(2) == 0) begin
      doc_bytes.push_back($urandom_range(1) ? "e" : "E");
      case ($urandom_range(2))
        0: doc_bytes.push_back("+");
        1: doc_bytes.push_back("-");
        default: ;
      endcase
      repeat ($urandom_range(1, 3)) doc_bytes.push_back(8'("0" + $urandom_range(9)));
    end
  endfunction

  function automatic void put_scalar();
    case ($urandom_range(4))
      0, 1: put_string();
      2, 3: put_number();
      default: begin
        case ($urandom_range(2))
          0:       put_text(literal_text(LitTrue));
          1:       put_text(literal_text(LitFalse));
          default: put_text(literal_text(LitNull));
        endcase
      end
    endcase
  endfunction

  // lvl is the depth of the enclosing container
  function automatic void put_value(int unsigned lvl, int unsigned max_lvl);
    if (lvl < max_lvl && $urandom_range(2) == 0) begin
      if ($urandom_range(1)) put_object(lvl + 1, max_lvl);
      else put_array(lvl + 1, max_lvl);
    end
    else put_scalar();
  endfunction

  function automatic void put_object(int unsigned lvl, int unsigned max_lvl);
    int unsigned n;
    n = $urandom_range(0, 3);
    doc_bytes.push_back("{");
    put_ws();
    for (int unsigned i = 0; i < n; i++) begin
      if (i != 0) doc_bytes.push_back(",");
      put_ws();
      put_string();
      put_ws();
      doc_bytes.push_back(":");
      put_ws();
      put_value(lvl, max_lvl);
      put_ws();
    end
    doc_bytes.push_back("}");
  endfunction

  function automatic void put_array(int unsigned lvl, int unsigned max_lvl);
    int unsigned n;
    n = $urandom_range(0, 3);
    doc_bytes.push_back("[");
    put_ws();
    for (int unsigned i = 0; i < n; i++) begin
      if (i != 0) doc_bytes.push_back(",");
      put_ws();
      put_value(lvl, max_lvl);
      put_ws();
    end
    doc_bytes.push_back("]");
  endfunction

  // Single chain of containers down to depth target
  function automatic void put_nested(int unsigned lvl, int unsigned target, logic as_obj);
    if (as_obj) put_text("{\"\":");
    else doc_bytes.push_back("[");
    if (lvl < target) put_nested(lvl + 1, target, 1'($urandom_range(1)));
    else put_scalar();
    doc_bytes.push_back(as_obj ? "}" : "]");
  endfunction

  // Break a well-formed document in one spot
  function automatic void mangle_doc();
    string       punct = ",:{}[]\"\\ 0eE.-+tfnu";
    int unsigned pos;
    int unsigned closers[$];
    pos = $urandom_range(doc_bytes.size() - 1);
    case ($urandom_range(5))
      0: doc_bytes[pos] = 8'($urandom_range(255));
      1: doc_bytes[pos] = punct[$urandom_range(punct.len() - 1)];
      2: doc_bytes = doc_bytes[0:pos];
      3: doc_bytes.push_back(8'($urandom_range(255)));
      4: doc_bytes.insert(pos, 8'($urandom_range(255)));
      default: begin
        foreach (doc_bytes[i])
          if (doc_bytes[i] == "}" || doc_bytes[i] == "]") closers.push_back(i);
        pos = closers[$urandom_range(closers.size() - 1)];
        doc_bytes[pos] = (doc_bytes[pos] == "}") ? "]" : "}";
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    in_word_t w;
    w.data_byte = b;
    w.last      = is_last;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    pending_status_q.push_back(syntax_status(b, is_last));
    bytes_sent++;
  endtask

  task automatic send_doc();
    foreach (doc_bytes[i]) send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
    doc_bytes.delete();
  endtask

  // Stop sending and wait for every outstanding word
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_reg    = v;
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  function automatic void log_failure(string what);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%s", what);
  endfunction

  always @(posedge clk_i) begin : check_results
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_status_q.size() == 0)
        log_failure($sformatf("unexpected word: status %0d level %0d",
                              out_word_o.status, out_word_o.nest_level));
      else begin
        want = pending_status_q.pop_front();
        if (out_word_o.status !== want.status || out_word_o.nest_level !== want.nest_level)
          log_failure($sformatf("mismatch: status exp %0d got %0d, level exp %0d got %0d",
                                want.status, out_word_o.status,
                                want.nest_level, out_word_o.nest_level));
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= rx_idle_pct);

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stall_cycles <= 0;
    else if (stall_cycles >= StallLimit) begin
      $display("json_syntax_validator_core_tb: errors");
      $finish;
    end
    else stall_cycles <= stall_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    put_text("\t{}\n");                       // whitespace around the top object
    send_doc();
    put_text("{\"a\":[1}]");                  // wrong closer, then latched error
    send_doc();
    doc_bytes.push_back(8'h00);               // zero byte
    send_doc();
    put_text("{\"");                          // high byte inside a key
    doc_bytes.push_back(8'hFF);
    put_text("\":null}");
    send_doc();
    put_text("{");                            // document cut short
    send_doc();
  endtask

  // Empty object, deepest legal chain, then one level more
  task automatic probe_depth(input int unsigned eff);
    put_text("{}");
    send_doc();
    if (eff > 0) begin
      put_nested(1, eff, 1'b1);
      send_doc();
    end
    put_nested(1, eff + 1, 1'b1);
    send_doc();
  endtask

  task automatic test_depth_limit();
    int unsigned trial_limits[$] = '{0, 1, 2, 63, 31};
    probe_depth(MaxNest);                     // reset value of the limit
    foreach (trial_limits[i]) begin
      write_limit(LimitW'(trial_limits[i]));
      probe_depth((trial_limits[i] > MaxNest) ? MaxNest : trial_limits[i]);
    end
    write_limit(LimitReset);
  endtask

  task automatic test_random_docs(input int unsigned n_bytes, input int unsigned lim);
    int unsigned stop_at;
    int unsigned pick;
    write_limit(LimitW'(lim));
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8)
        repeat ($urandom_range(1, 6)) doc_bytes.push_back(8'($urandom_range(255)));
      else begin
        put_ws();
        put_object(1, $urandom_range(1, 4));
        put_ws();
        if (pick < 30) mangle_doc();
      end
      send_doc();
    end
  endtask

  initial begin
    limit_reg = LimitReset;
    clear_parser();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_depth_limit();
    test_random_docs(190, $urandom_range(2, 5));
    tx_idle_pct = 82;
    rx_idle_pct = 13;
    test_random_docs(190, 32);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_docs(190, $urandom_range(3, 63));

    settle();
    repeat (4) @(posedge clk_i);
    if (pending_status_q.size() != 0)
      log_failure($sformatf("%0d words never arrived", pending_status_q.size()));
    if (fail_cnt == 0) $display("json_syntax_validator_core_tb: clean");
    else $display("json_syntax_validator_core_tb: errors");
    $finish;
  end

endmodule

FILE: filelist.f
src/jsv_pkg.sv
src/jsv_byte_class.sv
src/jsv_parser.sv
src/json_syntax_validator_core.sv
dv/json_syntax_validator_core_tb.sv
